### hdl/itoa_pkg.sv
// Package for the integer to ASCII formatter.
// Holds format codes, controller states, the emitter setup struct and the
// digit-to-character function. No dependencies.
package itoa_pkg;

  // Default sizes
  localparam int WORD_BITS_DEF      = 64;
  localparam int MAX_PAD_DIGITS_DEF = 32;

  // Digit position counter, covers any pad request up to 63
  localparam int POS_W = 6;

  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // Format codes carried in cmd
  typedef enum logic [1:0] {
    CMD_SDEC = 2'd0,
    CMD_UDEC = 2'd1,
    CMD_LHEX = 2'd2,
    CMD_UHEX = 2'd3
  } cmd_t;

  // Top-level controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Setup handed from the controller to the emitter
  typedef struct packed {
    logic             neg;
    logic             upper;
    logic [POS_W-1:0] pad_digits;
  } emit_cfg_t;

  // One digit (0..15) to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      ch = CH_UPPER_A + {4'd0, d} - 8'd10;
    end else begin
      ch = CH_LOWER_A + {4'd0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

### hdl/itoa_if.sv
// Valid/ready channel interfaces for the integer to ASCII formatter.
// Request carries one number to format, response carries one character.
// No dependencies.
interface itoa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] number;
  logic [5:0]  min_digit_count;

  modport source (output valid, cmd, number, min_digit_count, input ready);
  modport sink   (input valid, cmd, number, min_digit_count, output ready);
endinterface

interface itoa_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

### hdl/itoa_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Hex requests load the nibbles directly. Depends on itoa_pkg.
module itoa_conv import itoa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   hex,
  input  logic [WORD_BITS-1:0]   mag,
  output logic                   done,
  output logic [4*((WORD_BITS*30103)/100000+1)-1:0] digits
);

  localparam int DIG_N = (WORD_BITS * 30103) / 100000 + 1;
  localparam int BCD_W = 4 * DIG_N;
  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [WORD_BITS-1:0] sh;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     adj;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= start ? hex : (busy && (cnt == CNT_W'(1)));
      if (start) begin
        if (!hex) begin
          busy <= 1'b1;
          cnt  <= CNT_W'(WORD_BITS);
        end
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= hex ? BCD_W'(mag) : '0;
    end else if (busy) begin
      sh  <= {sh[WORD_BITS-2:0], 1'b0};
      bcd <= {adj[BCD_W-2:0], sh[WORD_BITS-1]};
    end
  end

  assign digits = bcd;

endmodule

### hdl/itoa_emit.sv
// Character emitter: walks digit positions from the top, one per cycle while the
// output register is free, drops leading zeros outside the pad width, drives
// the output register. Depends on itoa_pkg and itoa_if.
module itoa_emit import itoa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  emit_cfg_t        cfg,
  input  logic [4*((WORD_BITS*30103)/100000+1)-1:0] digits,
  output logic             done,
  itoa_rsp_if.source       rsp
);

  localparam int DIG_N = (WORD_BITS * 30103) / 100000 + 1;
  localparam int BCD_W = 4 * DIG_N;

  logic             active;
  logic             sign_pend;
  logic             seen;
  logic             upper;
  logic [POS_W-1:0] pad_digits;
  logic [POS_W-1:0] pos;
  logic [BCD_W-1:0] dig;
  logic             ovalid;
  logic [7:0]       ochar;
  logic             olast;

  logic             step;
  logic             in_reg;
  logic [3:0]       cur;
  logic             show;
  logic [POS_W-1:0] pos_start;

  // Current digit: positions above the register are padding zeros
  assign in_reg = pos < POS_W'(DIG_N);
  assign cur    = in_reg ? dig[BCD_W-1 -: 4] : 4'd0;
  assign show   = (pos < pad_digits) || seen || (cur != 4'd0) || (pos == '0);
  assign step   = active && (!ovalid || rsp.ready);

  assign pos_start = (cfg.pad_digits > POS_W'(DIG_N)) ? cfg.pad_digits - 1'b1
                                                      : POS_W'(DIG_N - 1);

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      sign_pend <= 1'b0;
      ovalid    <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= !load && step && !sign_pend && (pos == '0);
      if (!load && step && (sign_pend || show)) begin
        ovalid <= 1'b1;
      end else if (ovalid && rsp.ready) begin
        ovalid <= 1'b0;
      end
      if (load) begin
        active    <= 1'b1;
        sign_pend <= cfg.neg;
      end else if (step) begin
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else if (pos == '0) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Digit shift register and output payload
  always_ff @(posedge clk) begin
    if (load) begin
      dig        <= digits;
      pos        <= pos_start;
      seen       <= 1'b0;
      upper      <= cfg.upper;
      pad_digits <= cfg.pad_digits;
    end else if (step) begin
      if (sign_pend) begin
        ochar <= CH_MINUS;
        olast <= 1'b0;
      end else begin
        if (show) begin
          ochar <= digit_char(cur, upper);
          olast <= (pos == '0);
        end
        seen <= seen || (cur != 4'd0);
        if (pos != '0) begin
          pos <= pos - 1'b1;
        end
        if (in_reg) begin
          dig <= {dig[BCD_W-5:0], 4'd0};
        end
      end
    end
  end

  assign rsp.valid     = ovalid;
  assign rsp.out_char  = ochar;
  assign rsp.last_char = olast;

endmodule

### hdl/integer_to_ascii_formatter.sv
// Integer to ASCII formatter top level: request capture, sign handling,
// controller, converter and emitter. Depends on itoa_pkg, itoa_if,
// itoa_conv and itoa_emit.
//
//   channel | dir | payload                         | accepted when
//   req     | in  | cmd, number, min_digit_count    | req.valid && req.ready
//   rsp     | out | out_char, last_char             | rsp.valid && rsp.ready
//
// Flow: one item at a time. Decimal runs through the shift and add-3
// converter, hex loads directly, then the emitter walks one digit position
// per cycle while the output register is free, from max(min digits,
// decimal width) down to zero, plus one step for a sign.
// Reset: synchronous, clears the controller and the output valid.
// Stalls: the emitter holds while the output register is full; after the
// last character enters the output register, the emitter's done register
// and then the state register return to idle, where the next request is taken.
module integer_to_ascii_formatter import itoa_pkg::*; #(
  parameter int WORD_BITS      = WORD_BITS_DEF,
  parameter int MAX_PAD_DIGITS = MAX_PAD_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  itoa_req_if.sink   req,
  itoa_rsp_if.source rsp
);

  localparam int DIG_N = (WORD_BITS * 30103) / 100000 + 1;
  localparam int BCD_W = 4 * DIG_N;

  state_t               state;
  state_t               state_next;
  emit_cfg_t            cfg;
  emit_cfg_t            cfg_next;
  logic                 accept;
  logic [WORD_BITS-1:0] value;
  logic [WORD_BITS-1:0] mag;
  logic                 neg;
  logic                 hex;
  logic                 conv_done;
  logic                 emit_done;
  logic [BCD_W-1:0]     digits;

  // Request decode: sign, magnitude, saturated pad width
  assign accept = req.valid && req.ready;
  assign value  = req.number[WORD_BITS-1:0];
  assign neg    = (cmd_t'(req.cmd) == CMD_SDEC) && value[WORD_BITS-1];
  assign mag    = neg ? (~value + 1'b1) : value;
  assign hex    = req.cmd[1];

  always_comb begin
    cfg_next.neg        = neg;
    cfg_next.upper      = (cmd_t'(req.cmd) == CMD_UHEX);
    cfg_next.pad_digits = (req.min_digit_count > POS_W'(MAX_PAD_DIGITS))
                          ? POS_W'(MAX_PAD_DIGITS) : req.min_digit_count;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cfg <= cfg_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  itoa_conv #(
    .WORD_BITS (WORD_BITS)
  ) u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .hex    (hex),
    .mag    (mag),
    .done   (conv_done),
    .digits (digits)
  );

  itoa_emit #(
    .WORD_BITS (WORD_BITS)
  ) u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (conv_done),
    .cfg    (cfg),
    .digits (digits),
    .done   (emit_done),
    .rsp    (rsp)
  );

endmodule

### hdl/itoa_checker.sv
// Port-level checks for the integer to ASCII formatter, attached by bind.
// Depends on the top level's req and rsp interface ports.
module itoa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // One item at a time: no request taken right after one is accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous item in progress");

  // Characters other than the last mean the item is still in progress
  a_busy_mid_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("ready raised before the last character");

  // While idle only a last character may still wait
  a_idle_last_only: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> out_last)
    else $error("non-last character pending while idle");

  // Stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output item changed under stall");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_char  (rsp.out_char),
  .out_last  (rsp.last_char)
);

### sim/testbench.sv
// Self-checking testbench for integer_to_ascii_formatter: formats numbers in
// all four modes and compares every output character with a local predictor.
// Depends on itoa_pkg, itoa_if and the formatter RTL.
`timescale 1ns / 1ps

module testbench;
  import itoa_pkg::*;

  // Pending request item and one expected output character
  typedef struct {
    cmd_t        cmd;
    logic [63:0] number;
    logic [5:0]  pad_req;
  } number_req_t;

  typedef struct {
    logic [7:0] out_char;
    logic       last_char;
  } ascii_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  itoa_req_if req ();
  itoa_rsp_if rsp ();

  integer_to_ascii_formatter dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #4 clk = ~clk;

  number_req_t pending_numbers[$];
  ascii_char_t expected_chars[$];

  int   numbers_queued   = 0;
  int   numbers_accepted = 0;
  int   chars_checked    = 0;
  int   errors           = 0;
  int   send_idle_pct    = 0;
  int   recv_stall_pct   = 0;
  logic rx_hold          = 1'b0;
  logic pressure_start   = 1'b0;

  // Expected text for one number, most significant character first
  function automatic void push_formatted_text(cmd_t fmt, logic [63:0] value,
                                              logic [5:0] min_req);
    logic [63:0] mag;
    logic [7:0]  digit_buf [0:63];
    logic [3:0]  d;
    logic        neg;
    int          nd;
    int          pad;
    ascii_char_t ch;
    neg = (fmt == CMD_SDEC) && value[63];
    mag = neg ? -value : value;
    pad = (min_req > MAX_PAD_DIGITS_DEF) ? MAX_PAD_DIGITS_DEF : int'(min_req);
    nd  = 0;
    // digits least significant first
    do begin
      if (fmt == CMD_LHEX || fmt == CMD_UHEX) begin
        d   = mag[3:0];
        mag = mag >> 4;
      end else begin
        d   = 4'(mag % 64'd10);
        mag = mag / 64'd10;
      end
      if (d < 4'd10) begin
        digit_buf[nd] = "0" + 8'(d);
      end else if (fmt == CMD_UHEX) begin
        digit_buf[nd] = "A" + 8'(d) - 8'd10;
      end else begin
        digit_buf[nd] = "a" + 8'(d) - 8'd10;
      end
      nd++;
    end while (mag != 64'd0 && nd < 64);
    while (nd < pad) begin
      digit_buf[nd] = "0";
      nd++;
    end
    if (neg) begin
      ch.out_char  = "-";
      ch.last_char = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      ch.out_char  = digit_buf[i];
      ch.last_char = (i == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  task automatic queue_number(cmd_t fmt, logic [63:0] value, logic [5:0] min_req);
    number_req_t it;
    it.cmd     = fmt;
    it.number  = value;
    it.pad_req = min_req;
    pending_numbers.push_back(it);
    numbers_queued++;
  endtask

  // Random numbers of varied magnitude and sign, random pad requests
  task automatic queue_random_numbers(int n);
    logic [63:0] value;
    logic [5:0]  min_req;
    cmd_t        fmt;
    for (int k = 0; k < n; k++) begin
      fmt = cmd_t'($urandom_range(3));
      case ($urandom_range(5))
        0: value = {$urandom, $urandom};
        1: value = 64'($urandom_range(1000));
        2: value = {$urandom, $urandom} >> $urandom_range(63);
        3: value = -64'($urandom_range(1000));
        4: begin
          case ($urandom_range(5))
            0: value = 64'd0;
            1: value = '1;
            2: value = 64'h8000_0000_0000_0000;
            3: value = 64'h7FFF_FFFF_FFFF_FFFF;
            4: value = 64'd9999999999999999999;
            default: value = 64'd10000000000000000000;
          endcase
        end
        default: value = -({$urandom, $urandom} >> $urandom_range(63));
      endcase
      case ($urandom_range(6))
        0, 1:    min_req = 6'd0;
        2:       min_req = 6'($urandom_range(63, 33));
        default: min_req = 6'($urandom_range(32));
      endcase
      queue_number(fmt, value, min_req);
    end
  endtask

  // Request driver: offers pending items, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        push_formatted_text(cmd_t'(req.cmd), req.number, req.min_digit_count);
        numbers_accepted <= numbers_accepted + 1;
      end
      if (!req.valid || req.ready) begin
        if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req.valid           <= 1'b1;
          req.cmd             <= pending_numbers[0].cmd;
          req.number          <= pending_numbers[0].number;
          req.min_digit_count <= pending_numbers[0].pad_req;
          pending_numbers.pop_front();
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Character monitor: random backpressure, in-order compare
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_chars.size() == 0) begin
          if (errors < 10)
            $display("char %0d: unexpected '%s' (%h) last %b", chars_checked,
                     rsp.out_char, rsp.out_char, rsp.last_char);
          errors++;
        end else begin
          if (rsp.out_char !== expected_chars[0].out_char ||
              rsp.last_char !== expected_chars[0].last_char) begin
            if (errors < 10)
              $display("char %0d: expected '%s' (%h) last %b, got '%s' (%h) last %b",
                       chars_checked, expected_chars[0].out_char,
                       expected_chars[0].out_char, expected_chars[0].last_char,
                       rsp.out_char, rsp.out_char, rsp.last_char);
            errors++;
          end
          expected_chars.pop_front();
        end
        chars_checked++;
      end
      rsp.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the request side backs up
  initial begin
    wait (pressure_start);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (400) @(negedge clk);
    rx_hold = 1'b0;
  end

  // Stimulus and end of run
  initial begin
    req.valid           = 1'b0;
    req.cmd             = CMD_SDEC;
    req.number          = '0;
    req.min_digit_count = '0;
    rsp.ready           = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every format, zero, most negative, pad saturation
    queue_number(CMD_SDEC, 64'd0, 6'd0);
    queue_number(CMD_SDEC, 64'h8000_0000_0000_0000, 6'd0);
    queue_number(CMD_SDEC, '1, 6'd0);
    queue_number(CMD_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0);
    queue_number(CMD_UDEC, '1, 6'd0);
    queue_number(CMD_UDEC, 64'd0, 6'd32);
    queue_number(CMD_UDEC, 64'd1, 6'd63);
    queue_number(CMD_LHEX, '1, 6'd0);
    queue_number(CMD_UHEX, 64'hDEAD_BEEF_CAFE_F00D, 6'd0);
    queue_number(CMD_LHEX, 64'd0, 6'd0);
    queue_number(CMD_UHEX, 64'h0000_0000_00AB_CDEF, 6'd40);
    queue_number(CMD_SDEC, -64'd5, 6'd32);
    queue_number(CMD_SDEC, 64'h8000_0000_0000_0000, 6'd33);
    queue_number(CMD_UDEC, 64'd10000000000000000000, 6'd0);
    queue_number(CMD_LHEX, 64'h0123_4567_89AB_CDEF, 6'd17);
    queue_number(CMD_SDEC, 64'd12345, 6'd3);
    queue_number(CMD_UDEC, 64'd9, 6'd1);
    queue_number(CMD_UHEX, 64'hFEDC_BA98_7654_3210, 6'd63);
    queue_number(CMD_SDEC, 64'd0, 6'd63);
    queue_number(CMD_LHEX, 64'hFFFF_FFFF_FFFF_FFFF, 6'd16);
    while (pending_numbers.size() != 0) @(negedge clk);

    // Random, no idling, with the long receiver hold-off
    pressure_start = 1'b1;
    queue_random_numbers(22);
    while (pending_numbers.size() != 0) @(negedge clk);

    // Random, sender mostly idle
    send_idle_pct = 63;
    queue_random_numbers(22);
    while (pending_numbers.size() != 0) @(negedge clk);

    // Random, receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 63;
    queue_random_numbers(22);
    while (pending_numbers.size() != 0) @(negedge clk);

    // Random, light idling on both sides
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    queue_random_numbers(22);

    // Drain
    while (numbers_accepted != numbers_queued) @(negedge clk);
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);

    if (errors == 0 && expected_chars.size() == 0) begin
      $display("PASS integer_to_ascii_formatter");
    end else begin
      $display("FAIL integer_to_ascii_formatter");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL integer_to_ascii_formatter");
    $finish;
  end

endmodule
